### hdl/ctsat_pkg.sv
// package with types and constants shared by the tree store and walker
`timescale 1ns / 1ps

package ctsat_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int VALUE_W  = 32;

    localparam logic [CNT_W-1:0] NO_NODE = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_INORDER   = 2'd1,
        OP_PREORDER  = 2'd2,
        OP_POSTORDER = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_WALK   = 1'b1
    } cmd_kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } back_state_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [VALUE_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value_out;
        status_t                    status;
        logic                       last;
    } res_item_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        opcode_t                    order;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

endpackage

### hdl/ctsat_front.sv
// front end: accepts items, classifies them and queues commands for the back end
`timescale 1ns / 1ps

module ctsat_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ctsat_pkg::in_item_t item,
    output logic              cmd_valid,
    output ctsat_pkg::cmd_t   cmd,
    input  logic              cmd_pop
);
    import ctsat_pkg::*;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = CQ_PTR_W + 1;

    cmd_t                 entry_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]  wr_ptr_reg;
    logic [CQ_PTR_W-1:0]  wr_ptr_next;
    logic [CQ_PTR_W-1:0]  rd_ptr_reg;
    logic [CQ_PTR_W-1:0]  rd_ptr_next;
    logic [CQ_CNT_W-1:0]  count_reg;
    logic [CQ_CNT_W-1:0]  count_next;
    logic                 do_push;
    logic                 do_pop;
    cmd_t                 classified;

    assign full      = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        classified.order = item.opcode;
        classified.value = item.value;
        unique case (item.opcode)
            OP_INSERT:
                classified.kind = CMD_INSERT;
            default:
                classified.kind = CMD_WALK;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

### hdl/ctsat_out_queue.sv
// result queue between the back end and the result ports
`timescale 1ns / 1ps

module ctsat_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_push,
    input  ctsat_pkg::res_item_t res_in,
    output logic                 res_full,
    output logic                 empty,
    input  logic                 pop,
    output ctsat_pkg::res_item_t result
);
    import ctsat_pkg::*;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = RQ_PTR_W + 1;

    res_item_t            entry_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  wr_ptr_reg;
    logic [RQ_PTR_W-1:0]  rd_ptr_reg;
    logic [RQ_CNT_W-1:0]  count_reg;
    logic [RQ_CNT_W-1:0]  count_next;
    logic                 do_push;
    logic                 do_pop;

    assign res_full = (count_reg == RQ_CNT_W'(RQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign result   = entry_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= res_in;
        end
    end

    // the back end must never push into a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && res_full))
        else $error("result pushed while queue full");

endmodule

### hdl/ctsat_back.sv
// back end: node store, insert handling and stackless tree walker
`timescale 1ns / 1ps

module ctsat_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  ctsat_pkg::cmd_t      cmd,
    output logic                 cmd_pop,
    output logic                 res_push,
    output ctsat_pkg::res_item_t res_out,
    input  logic                 res_full
);
    import ctsat_pkg::*;

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [ADDR_W-1:0]         cur_reg;
    logic [ADDR_W-1:0]         cur_next;
    logic [CNT_W-1:0]          prev_reg;
    logic [CNT_W-1:0]          prev_next;
    logic [CNT_W-1:0]          emitted_reg;
    logic [CNT_W-1:0]          emitted_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    opcode_t                   order_reg;
    opcode_t                   order_next;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      mem_we;

    logic [CNT_W:0]            left_idx;
    logic [CNT_W:0]            right_idx;
    logic [CNT_W:0]            prev_wide;
    logic                      has_left;
    logic                      has_right;
    logic                      from_left;
    logic                      from_right;
    logic                      emit;
    logic                      go_down;
    logic [ADDR_W-1:0]         down_idx;
    logic [ADDR_W-1:0]         up_idx;
    logic                      walk_done;
    logic                      step;

    // one step of the walk from the current node
    always_comb
    begin
        left_idx   = {1'b0, cur_reg, 1'b1};
        right_idx  = {1'b0, cur_reg, 1'b0} + (CNT_W + 1)'(2);
        prev_wide  = {1'b0, prev_reg};
        has_left   = left_idx < {1'b0, count_reg};
        has_right  = right_idx < {1'b0, count_reg};
        from_left  = (prev_wide == left_idx);
        from_right = (prev_wide == right_idx);
        emit       = 1'b0;
        go_down    = 1'b0;
        down_idx   = left_idx[ADDR_W-1:0];
        if (!from_left && !from_right)
        begin
            if (order_reg == OP_PREORDER)
            begin
                emit = 1'b1;
            end
            if (has_left)
            begin
                go_down = 1'b1;
            end
            else
            begin
                if (order_reg == OP_INORDER)
                begin
                    emit = 1'b1;
                end
                if (has_right)
                begin
                    go_down  = 1'b1;
                    down_idx = right_idx[ADDR_W-1:0];
                end
                else if (order_reg == OP_POSTORDER)
                begin
                    emit = 1'b1;
                end
            end
        end
        else if (from_left)
        begin
            if (order_reg == OP_INORDER)
            begin
                emit = 1'b1;
            end
            if (has_right)
            begin
                go_down  = 1'b1;
                down_idx = right_idx[ADDR_W-1:0];
            end
            else if (order_reg == OP_POSTORDER)
            begin
                emit = 1'b1;
            end
        end
        else if (order_reg == OP_POSTORDER)
        begin
            emit = 1'b1;
        end
        up_idx    = (cur_reg - 1'b1) >> 1;
        walk_done = !go_down && (cur_reg == '0);
    end

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        emitted_next = emitted_reg;
        count_next   = count_reg;
        order_next   = order_reg;
        rd_addr      = '0;
        mem_we       = 1'b0;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        step         = 1'b0;
        res_out.value_out = '0;
        res_out.status    = STATUS_OK;
        res_out.last      = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_INSERT:
                        begin
                            res_push = 1'b1;
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                res_out.status = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_WALK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_push       = 1'b1;
                                res_out.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next   = ST_WALK;
                                cur_next     = '0;
                                prev_next    = NO_NODE;
                                emitted_next = '0;
                                order_next   = cmd.order;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                rd_addr = cur_reg;
                if (!res_full)
                begin
                    step              = 1'b1;
                    res_push          = emit;
                    res_out.value_out = rd_data_reg;
                    res_out.last      = (emitted_reg == count_reg - 1'b1);
                    if (emit)
                    begin
                        emitted_next = emitted_reg + 1'b1;
                    end
                    if (walk_done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        prev_next = {1'b0, cur_reg};
                        cur_next  = go_down ? down_idx : up_idx;
                        rd_addr   = cur_next;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            prev_reg    <= '0;
            emitted_reg <= '0;
            count_reg   <= '0;
            order_reg   <= OP_INORDER;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            emitted_reg <= emitted_next;
            count_reg   <= count_next;
            order_reg   <= order_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[ADDR_W-1:0]] <= cmd.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // a finished walk has delivered every stored node exactly once
    a_walk_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && step && walk_done) |-> (emitted_next == count_reg))
        else $error("walk ended with wrong number of results");

    // during a walk no more results than nodes have gone out
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (emitted_reg <= count_reg))
        else $error("walk produced too many results");

    // the node count only ever grows by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1))
        else $error("node count jumped");

    // the count stays within the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (count_reg <= CNT_W'(CAPACITY)))
        else $error("node count above capacity");

endmodule

### hdl/complete_tree_store_and_traversal_core.sv
// top level: complete binary tree store with in-order, pre-order and post-order walks
`timescale 1ns / 1ps

// Items enter through a two-entry command queue and results leave through a four-entry
// result queue. An insert gives one result. A walk of a tree of n nodes is run by the
// stackless walker, which moves along one tree edge per cycle while the result queue is not
// full (each edge down and up once, 2n-1 steps) and reads one node per cycle from the single
// read port of the node memory. A walk gives n results; a walk of an empty store gives one
// empty-status result. The back end pauses whenever the result queue is full.
module complete_tree_store_and_traversal_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ctsat_pkg::in_item_t  item,
    output logic                 empty,
    input  logic                 pop,
    output ctsat_pkg::res_item_t result
);
    import ctsat_pkg::*;

    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_pop;
    logic      res_push;
    res_item_t res_item;
    logic      res_full;

    ctsat_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ctsat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_out   (res_item),
        .res_full  (res_full)
    );

    ctsat_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_item),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule
